// ----- rtl/smx_pkg.sv -----
// Shared types and constants for the stack machine executor.
package smx_pkg;

    localparam int WORD_W        = 32;
    localparam int OPC_W         = 8;
    localparam int IMM_W         = 24;
    localparam int OPC_LSB       = 24;
    localparam int KIND_W        = 3;
    localparam int DEPTH_FIELD_W = 5;
    localparam int OUT_DATA_W    = 40;   // value + depth, padded to whole bytes

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [OPC_W-1:0]  opcode_t;

    localparam opcode_t OP_HALT  = 8'd0;
    localparam opcode_t OP_PUSH  = 8'd1;
    localparam opcode_t OP_ADD   = 8'd2;
    localparam opcode_t OP_SUB   = 8'd3;
    localparam opcode_t OP_MUL   = 8'd4;
    localparam opcode_t OP_WRINT = 8'd8;
    localparam opcode_t OP_WRCHR = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_INT   = 3'd1,
        KIND_CHR   = 3'd2,
        KIND_HALT  = 3'd3,
        KIND_OVER  = 3'd4,
        KIND_UNDER = 3'd5
    } kind_t;

    // What a stack cell loads this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_ABOVE,   // neighbor nearer the top (push / load at cell 0)
        CELL_FROM_BELOW    // neighbor deeper in the stack (pop)
    } cell_op_t;

    typedef struct packed {
        cell_op_t top_op;    // cell 0
        cell_op_t rest_op;   // all deeper cells
    } stack_ctl_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

endpackage

// ----- rtl/smx_cell.sv -----
// One stack entry: holds a word and takes its neighbor's word on a shift.
module smx_cell
    import smx_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  word_t    above,
    input  word_t    below,
    output word_t    q
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        unique case (op)
            CELL_FROM_ABOVE: data_next = above;
            CELL_FROM_BELOW: data_next = below;
            CELL_HOLD:       data_next = data_reg;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- rtl/smx_alu.sv -----
// Arithmetic on the two top stack entries; wraps modulo 2^32.
module smx_alu
    import smx_pkg::*;
(
    input  alu_op_t op,
    input  word_t   second,
    input  word_t   top,
    output word_t   result
);

    word_t product;

    // low word of the product only
    assign product = second * top;

    always_comb
    begin
        unique case (op)
            ALU_ADD: result = second + top;
            ALU_SUB: result = second - top;
            ALU_MUL: result = product;
            default: result = product;
        endcase
    end

endmodule

// ----- rtl/stack_machine_executor.sv -----
// Stack machine executor: a shifting row of stack cells, one instruction per beat.
// A result beat is registered in the output register, or in the skid stage while that is held.
// Throughput: one instruction per cycle while s_tready is high; the top two cells feed
//   the ALU; its result lands in cell 0 in the same cycle, so dependents go back to back.
// s_tready falls only when two result beats are waiting (output register plus skid).
// Reset clears depth, last written value, stop flag and handshake; stack cells keep garbage.
module stack_machine_executor
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // [31:0] instruction
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] value, [36:32] depth, rest zero
    output logic [KIND_W-1:0]     m_tuser    // [2:0] kind
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // ---------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    word_t              last_wr_reg, last_wr_next;
    logic               stopped_reg, stopped_next;

    word_t cell_q [STACK_DEPTH];

    // ---------------------------------------------------------------
    // Decode / execute
    // ---------------------------------------------------------------
    logic       in_acc;
    opcode_t    opc;
    word_t      imm;
    alu_op_t    alu_op;
    word_t      alu_result;
    word_t      load_data;
    logic       load_push;
    stack_ctl_t ctl, ctl_gated;
    kind_t      res_kind;
    word_t      res_value;

    logic [DEPTH_W+DEPTH_FIELD_W-1:0] depth_ext;
    logic [DEPTH_FIELD_W-1:0]         res_depth;

    assign in_acc = s_tvalid && s_tready;
    assign opc    = s_tdata[OPC_LSB +: OPC_W];
    assign imm    = {{(WORD_W-IMM_W){1'b0}}, s_tdata[IMM_W-1:0]};

    always_comb
    begin
        priority if (opc == OP_ADD)
            alu_op = ALU_ADD;
        else if (opc == OP_SUB)
            alu_op = ALU_SUB;
        else
            alu_op = ALU_MUL;
    end

    smx_alu u_alu (
        .op     (alu_op),
        .second (cell_q[1]),
        .top    (cell_q[0]),
        .result (alu_result)
    );

    always_comb
    begin
        depth_next   = depth_reg;
        last_wr_next = last_wr_reg;
        stopped_next = stopped_reg;
        res_kind     = KIND_NONE;
        res_value    = '0;
        load_push    = 1'b0;
        ctl.top_op   = CELL_HOLD;
        ctl.rest_op  = CELL_HOLD;

        // a stopped block ignores every instruction
        if (!stopped_reg)
        begin
            unique case (opc)
                OP_HALT:
                begin
                    stopped_next = 1'b1;
                    res_kind     = KIND_HALT;
                    res_value    = last_wr_reg;
                end
                OP_PUSH:
                begin
                    if (depth_reg >= DEPTH_W'(STACK_DEPTH))
                    begin
                        stopped_next = 1'b1;
                        res_kind     = KIND_OVER;
                    end
                    else
                    begin
                        load_push   = 1'b1;
                        ctl.top_op  = CELL_FROM_ABOVE;
                        ctl.rest_op = CELL_FROM_ABOVE;
                        depth_next  = depth_reg + DEPTH_W'(1);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (depth_reg < DEPTH_W'(2))
                    begin
                        stopped_next = 1'b1;
                        res_kind     = KIND_UNDER;
                    end
                    else
                    begin
                        // result replaces second; deeper entries move up one
                        ctl.top_op  = CELL_FROM_ABOVE;
                        ctl.rest_op = CELL_FROM_BELOW;
                        depth_next  = depth_reg - DEPTH_W'(1);
                    end
                end
                OP_WRINT, OP_WRCHR:
                begin
                    if (depth_reg == '0)
                    begin
                        stopped_next = 1'b1;
                        res_kind     = KIND_UNDER;
                    end
                    else
                    begin
                        ctl.top_op  = CELL_FROM_BELOW;
                        ctl.rest_op = CELL_FROM_BELOW;
                        depth_next  = depth_reg - DEPTH_W'(1);
                        res_value   = cell_q[0];
                        if (opc == OP_WRINT)
                        begin
                            res_kind     = KIND_INT;
                            last_wr_next = cell_q[0];
                        end
                        else
                        begin
                            res_kind = KIND_CHR;
                        end
                    end
                end
                default:
                begin
                    // divide, modulo, read and unknown opcodes: no-op
                end
            endcase
        end
    end

    assign load_data = load_push ? imm : alu_result;

    always_comb
    begin
        ctl_gated = ctl;
        if (!in_acc)
        begin
            ctl_gated.top_op  = CELL_HOLD;
            ctl_gated.rest_op = CELL_HOLD;
        end
    end

    assign depth_ext = {{DEPTH_FIELD_W{1'b0}}, depth_next};
    assign res_depth = depth_ext[DEPTH_FIELD_W-1:0];

    // ---------------------------------------------------------------
    // Stack: chain of cells, cell 0 is the top
    // ---------------------------------------------------------------
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        word_t    above_w;
        word_t    below_w;
        cell_op_t op_w;

        if (i == 0)
        begin : g_top
            assign above_w = load_data;
            assign op_w    = ctl_gated.top_op;
        end
        else
        begin : g_mid
            assign above_w = cell_q[i-1];
            assign op_w    = ctl_gated.rest_op;
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below_w = '0;
        end
        else
        begin : g_inner
            assign below_w = cell_q[i+1];
        end

        smx_cell u_cell (
            .clk   (clk),
            .op    (op_w),
            .above (above_w),
            .below (below_w),
            .q     (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            last_wr_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            depth_reg   <= depth_next;
            last_wr_reg <= last_wr_next;
            stopped_reg <= stopped_next;
        end
    end

    // ---------------------------------------------------------------
    // Result beats: output register plus skid stage
    // ---------------------------------------------------------------
    typedef struct packed {
        kind_t                    kind;
        word_t                    value;
        logic [DEPTH_FIELD_W-1:0] depth;
    } result_t;

    result_t res_new;
    result_t out_reg, skid_reg;
    logic    out_vld_reg, skid_vld_reg;
    logic    out_pop;

    assign res_new.kind  = res_kind;
    assign res_new.value = res_value;
    assign res_new.depth = res_depth;

    assign out_pop  = m_tvalid && m_tready;
    assign s_tready = !skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            // skid is empty whenever a beat is accepted
            if (!out_vld_reg || out_pop)
            begin
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (out_pop)
        begin
            if (skid_vld_reg)
            begin
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (!out_vld_reg || out_pop)
            begin
                out_reg <= res_new;
            end
            else
            begin
                skid_reg <= res_new;
            end
        end
        else if (out_pop && skid_vld_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {{(OUT_DATA_W-WORD_W-DEPTH_FIELD_W){1'b0}}, out_reg.depth, out_reg.value};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a beat while output register is empty");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    a_stopped_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && in_acc) |=> ($stable(depth_reg) && $stable(last_wr_reg)))
        else $error("stopped block changed its state");

    a_int_remembered: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && res_kind == KIND_INT) |=> last_wr_reg == $past(res_value))
        else $error("written integer not remembered");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (res_kind == KIND_OVER || res_kind == KIND_UNDER
                    || res_kind == KIND_HALT)) |=> stopped_reg)
        else $error("halt or stack error did not stop the block");

endmodule
